// ===== hw/rtl/bbl_pkg.sv =====
// Package for the 3x3 box blur: shared types, register codes and divide constants.
// Used by every module under hw/rtl; depends on nothing.
package bbl_pkg;

    localparam int PIX_W        = 8;
    localparam int SIZE_W       = 10;
    localparam int SUM_W        = 12;
    localparam int MIN_SIZE     = 3;
    localparam int HEIGHT_LIMIT = 512;
    localparam int SIZE_RESET   = 512;

    // floor(x / 9) == (x * 7282) >> 16 for every x up to 9 * 255
    localparam int                 DIV9_MULT_W = 13;
    localparam int                 DIV9_SHIFT  = 16;
    localparam int                 PROD_W      = 25;
    localparam logic [DIV9_MULT_W-1:0] DIV9_MULT = 13'd7282;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    // per-pixel decisions handed from the position counters to the datapath
    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } pix_flags_t;

endpackage

// ===== hw/rtl/bbl_regs.sv =====
// Configuration registers of the box blur: APB write/read and size saturation.
// Depends on bbl_pkg.
module bbl_regs #(
    parameter int MAX_WIDTH = 512,
    parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [WW-1:0]             width_eff,
    output logic [bbl_pkg::SIZE_W-1:0] height_eff,
    output logic                      restart
);

    logic [bbl_pkg::SIZE_W-1:0] frame_width_reg;
    logic [bbl_pkg::SIZE_W-1:0] frame_height_reg;
    bbl_pkg::reg_idx_t          idx;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign idx     = bbl_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign restart = wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bbl_pkg::SIZE_W'(bbl_pkg::SIZE_RESET);
            frame_height_reg <= bbl_pkg::SIZE_W'(bbl_pkg::SIZE_RESET);
        end
        else if (wr_en)
        begin
            unique case (idx)
                bbl_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[bbl_pkg::SIZE_W-1:0];
                bbl_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[bbl_pkg::SIZE_W-1:0];
                default:                   frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            bbl_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            bbl_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:                   prdata = '0;
        endcase
    end

    // saturate sizes to the supported range
    always_comb
    begin
        if (32'(frame_width_reg) < 32'(bbl_pkg::MIN_SIZE))
            width_eff = WW'(bbl_pkg::MIN_SIZE);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(frame_width_reg);

        if (32'(frame_height_reg) < 32'(bbl_pkg::MIN_SIZE))
            height_eff = bbl_pkg::SIZE_W'(bbl_pkg::MIN_SIZE);
        else if (32'(frame_height_reg) > 32'(bbl_pkg::HEIGHT_LIMIT))
            height_eff = bbl_pkg::SIZE_W'(bbl_pkg::HEIGHT_LIMIT);
        else
            height_eff = frame_height_reg;
    end

endmodule

// ===== hw/rtl/bbl_ctrl.sv =====
// Raster position counters of the box blur: accept/ignore decision and per-pixel flags.
// Depends on bbl_pkg.
module bbl_ctrl #(
    parameter int MAX_WIDTH = 512,
    parameter int AW        = $clog2(MAX_WIDTH),
    parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [WW-1:0]              width_eff,
    input  logic [bbl_pkg::SIZE_W-1:0] height_eff,
    input  logic                       restart,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       in_flush,
    output logic                       act,
    output logic [AW-1:0]              col,
    output bbl_pkg::pix_flags_t        flags
);

    logic [AW-1:0]              col_reg;
    logic [AW-1:0]              col_next;
    logic [bbl_pkg::SIZE_W-1:0] row_reg;
    logic [bbl_pkg::SIZE_W-1:0] row_next;
    logic [WW-1:0]              col_inc;
    logic                       draining;
    logic                       accept;

    assign accept   = in_valid & in_ready;
    assign draining = row_reg >= height_eff;
    // a flush counts only while draining, a pixel only before it
    assign act      = accept & (in_flush == draining);
    assign col      = col_reg;
    assign col_inc  = WW'(col_reg) + WW'(1);

    always_comb
    begin
        flags.emit     = (row_reg >= bbl_pkg::SIZE_W'(2)) ||
                         ((row_reg == bbl_pkg::SIZE_W'(1)) && (col_reg != '0));
        flags.interior = (col_reg >= AW'(2)) && (row_reg >= bbl_pkg::SIZE_W'(2)) &&
                         (row_reg < height_eff);
        flags.last     = (row_reg == height_eff + bbl_pkg::SIZE_W'(1)) && (col_reg == '0);

        col_next = col_reg;
        row_next = row_reg;
        if (flags.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = row_reg + bbl_pkg::SIZE_W'(1);
        end
        else
        begin
            col_next = AW'(col_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (act)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_frame_wrap : assert property (@(posedge clk) disable iff (!rst_n)
        act && flags.last |=> (col_reg == '0) && (row_reg == '0))
        else $error("position counters did not return to zero after frame end");

    a_ignored_item : assert property (@(posedge clk) disable iff (!rst_n)
        accept && !act && !restart |=> $stable(col_reg) && $stable(row_reg))
        else $error("ignored request moved the position counters");

    a_row_bound : assert property (@(posedge clk) disable iff (!rst_n)
        $past(restart) |-> (row_reg == '0) && (col_reg == '0))
        else $error("register write did not restart the frame");
`endif

endmodule

// ===== hw/rtl/bbl_line_buf.sv =====
// Two line buffers of the box blur (line two above and one above the incoming pixel).
// Registered reads; the shift of the column into the upper line is written in the cycle after the read.
// Depends on bbl_pkg.
module bbl_line_buf #(
    parameter int MAX_WIDTH = 512,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    input  logic [bbl_pkg::PIX_W-1:0] wr_pix,
    output logic [bbl_pkg::PIX_W-1:0] top,
    output logic [bbl_pkg::PIX_W-1:0] mid
);

    logic [bbl_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [bbl_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [bbl_pkg::PIX_W-1:0] top_reg;
    logic [bbl_pkg::PIX_W-1:0] mid_reg;
    logic [bbl_pkg::PIX_W-1:0] wr_pix_reg;
    logic [AW-1:0]             wr_addr_reg;
    logic                      wr_pend_reg;

    assign top = top_reg;
    assign mid = mid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_pend_reg <= 1'b0;
        else
            wr_pend_reg <= rd_en;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            top_reg     <= upper_mem[rd_addr];
            mid_reg     <= middle_mem[rd_addr];
            wr_addr_reg <= rd_addr;
            wr_pix_reg  <= wr_pix;
        end
    end

    // push the column up one line: middle moves to upper, the new pixel into middle
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            upper_mem[wr_addr_reg]  <= mid_reg;
            middle_mem[wr_addr_reg] <= wr_pix_reg;
        end
    end

endmodule

// ===== hw/rtl/bbl_window.sv =====
// 3x3 window and output stage of the box blur: shift window, sum, divide by nine (centre on borders), hold result.
// Depends on bbl_pkg.
module bbl_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_act,
    output logic                      in_ready,
    input  logic [bbl_pkg::PIX_W-1:0] in_pix,
    input  bbl_pkg::pix_flags_t       in_flags,
    input  logic [bbl_pkg::PIX_W-1:0] top,
    input  logic [bbl_pkg::PIX_W-1:0] mid,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [bbl_pkg::PIX_W-1:0] out_pixel,
    output logic                      out_last
);

    logic                      s1_valid_reg;
    logic [bbl_pkg::PIX_W-1:0] s1_pix_reg;
    bbl_pkg::pix_flags_t       s1_flags_reg;
    logic                      s2_valid_reg;
    bbl_pkg::pix_flags_t       s2_flags_reg;
    logic [bbl_pkg::PIX_W-1:0] win_reg [9];
    logic                      out_valid_reg;
    logic [bbl_pkg::PIX_W-1:0] out_pixel_reg;
    logic                      out_last_reg;

    logic                          out_free;
    logic                          s2_take;
    logic                          s2_adv;
    logic                          s1_adv;
    logic [bbl_pkg::SUM_W-1:0]     sum;
    logic [bbl_pkg::PROD_W-1:0]    prod;
    logic [bbl_pkg::PIX_W-1:0]     mean;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_take  = !s2_valid_reg || out_free;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s1_adv   = s1_valid_reg && s2_take;
    assign in_ready = !s1_valid_reg || s2_take;

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_act;
            if (s2_take)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg && s2_flags_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_act)
        begin
            s1_pix_reg   <= in_pix;
            s1_flags_reg <= in_flags;
        end
        if (s1_adv)
        begin
            s2_flags_reg <= s1_flags_reg;
            for (int r = 0; r < 3; r++)
            begin
                win_reg[3*r]     <= win_reg[3*r + 1];
                win_reg[3*r + 1] <= win_reg[3*r + 2];
            end
            win_reg[2] <= top;
            win_reg[5] <= mid;
            win_reg[8] <= s1_pix_reg;
        end
        if (s2_adv)
        begin
            out_pixel_reg <= s2_flags_reg.interior ? mean : win_reg[4];
            out_last_reg  <= s2_flags_reg.last;
        end
    end

    // floor(sum / 9) by reciprocal multiply
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 9; i++)
            sum = sum + bbl_pkg::SUM_W'(win_reg[i]);
        prod = bbl_pkg::PROD_W'(sum) * bbl_pkg::PROD_W'(bbl_pkg::DIV9_MULT);
        mean = prod[bbl_pkg::DIV9_SHIFT +: bbl_pkg::PIX_W];
    end

endmodule

// ===== hw/rtl/box_blur_3x3_unit.sv =====
// 3x3 box blur over 8-bit grayscale frames in raster order.
// Throughput: one request per clock while m_tready does not stall the output. A result is
// presented on m_tvalid once the request completing it has passed the window stage, then the output register.
// Results trail input by one line plus one pixel; flush requests drain the tail of the frame.
// Reset clears the position counters and all valid flags and sets both sizes to 512.
// Line buffers are not cleared at reset; their first frame fills them before any use.
module box_blur_3x3_unit #(
    parameter int MAX_WIDTH = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    // pixel input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_in
    input  logic        s_tuser,   // [0] flush
    // filtered pixel output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] pixel_out
    output logic        m_tlast,   // frame_last
    // configuration (frame_width at 0x0, frame_height at 0x4)
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [WW-1:0]                width_eff;
    logic [bbl_pkg::SIZE_W-1:0]   height_eff;
    logic                         restart;
    logic                         act;
    logic [AW-1:0]                col;
    bbl_pkg::pix_flags_t          flags;
    logic [bbl_pkg::PIX_W-1:0]    pix;
    logic [bbl_pkg::PIX_W-1:0]    top;
    logic [bbl_pkg::PIX_W-1:0]    mid;

    // a flush shifts a zero pixel in; only border results ever see it
    assign pix = s_tuser ? '0 : s_tdata;

    // register file: any write restarts the frame
    bbl_regs #(
        .MAX_WIDTH (MAX_WIDTH),
        .WW        (WW)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .restart    (restart)
    );

    // position tracking: drop pixels during drain and flushes before frame end
    bbl_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW),
        .WW        (WW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .restart    (restart),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_flush   (s_tuser),
        .act        (act),
        .col        (col),
        .flags      (flags)
    );

    // read the column above the incoming pixel at accept time
    bbl_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (act),
        .rd_addr (col),
        .wr_pix  (pix),
        .top     (top),
        .mid     (mid)
    );

    // window shift, mean and output register; ready flows back from here
    bbl_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_act    (act),
        .in_ready  (s_tready),
        .in_pix    (pix),
        .in_flags  (flags),
        .top       (top),
        .mid       (mid),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_pixel (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
